// ===== sv/bmpq_pkg.sv =====
// Package for the bounded max priority queue.
// Word types, operation and status codes, sequencer states. No dependencies.
package bmpq_pkg;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    // Input word
    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
        logic                     is_empty;
        logic [COUNT_W-1:0]       count;
    } t_out_word;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_POP,
        S_DONE
    } t_state;

endpackage

// ===== sv/bmpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module bmpq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bmpq_seq.sv =====
// Sequencer and shared compare unit for the bounded max priority queue.
// Depends on bmpq_pkg; drives the entry RAM ports.
module bmpq_seq #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned AW       = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  bmpq_pkg::t_in_word          i_in_word,
    output logic                        o_done,
    input  logic                        i_take,
    output bmpq_pkg::t_out_word         o_out_word,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [bmpq_pkg::DATA_W-1:0] o_wdata,
    output logic [AW-1:0]               o_raddr,
    input  logic [bmpq_pkg::DATA_W-1:0] i_rdata
);
    import bmpq_pkg::*;

    localparam int unsigned FW = $clog2(CAPACITY + 1);

    t_state                    r_state, n_state;
    logic [FW-1:0]             r_fill, n_fill;
    logic [AW-1:0]             r_pos, n_pos;
    logic [1:0]                r_mode, n_mode;
    logic signed [DATA_W-1:0]  r_val, n_val;
    logic signed [DATA_W-1:0]  r_res, n_res;
    logic [1:0]                r_status, n_status;

    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_is_ins;
    logic w_is_pop;
    logic w_gt;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_full   = (r_fill == FW'(CAPACITY));
    assign w_empty  = (r_fill == '0);
    assign w_is_ins = (i_in_word.mode == MODE_INSERT);
    assign w_is_pop = (i_in_word.mode == MODE_REMOVE) || (i_in_word.mode == MODE_PEEK);

    // Shared compare unit: stored entry against the value being inserted
    assign w_gt = ($signed(i_rdata) > r_val);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_ins) begin
                        if (w_full) begin
                            n_state = S_DONE;
                        end else if (w_empty) begin
                            n_state = S_INS_PUT;
                        end else begin
                            n_state = S_INS_CMP;
                        end
                    end else if (w_is_pop) begin
                        n_state = w_empty ? S_DONE : S_POP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INS_CMP: begin
                if (w_gt) begin
                    n_state = (r_pos == AW'(1)) ? S_INS_PUT : S_INS_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS_PUT: n_state = S_DONE;
            S_POP:     n_state = S_DONE;
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        o_we       = 1'b0;
        o_waddr    = r_pos;
        o_wdata    = r_val;
        o_raddr    = AW'(r_fill - FW'(1));
        n_fill     = r_fill;
        n_pos      = r_pos;
        n_mode     = r_mode;
        n_val      = r_val;
        n_res      = r_res;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    n_mode   = i_in_word.mode;
                    n_val    = i_in_word.value;
                    n_pos    = AW'(r_fill);
                    n_res    = '0;
                    n_status = ST_OK;
                    if (w_is_ins && w_full) begin
                        n_status = ST_OVERFLOW;
                    end else if (w_is_pop && w_empty) begin
                        n_status = ST_UNDERFLOW;
                    end
                end
            end
            S_INS_CMP: begin
                // rdata holds the entry just below the gap at r_pos
                o_we = 1'b1;
                if (w_gt) begin
                    o_wdata = i_rdata;
                    n_pos   = r_pos - AW'(1);
                    o_raddr = r_pos - AW'(2);
                end else begin
                    n_fill = r_fill + FW'(1);
                end
            end
            S_INS_PUT: begin
                o_we   = 1'b1;
                n_fill = r_fill + FW'(1);
            end
            S_POP: begin
                n_res = $signed(i_rdata);
                if (r_mode == MODE_REMOVE) begin
                    n_fill = r_fill - FW'(1);
                end
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_mode   <= n_mode;
        r_val    <= n_val;
        r_res    <= n_res;
        r_status <= n_status;
    end

    // Result word as seen after this operation
    always_comb begin
        o_out_word.result_value = r_res;
        o_out_word.status       = r_status;
        o_out_word.is_empty     = (r_fill == '0);
        o_out_word.count        = COUNT_W'(r_fill);
    end

endmodule

// ===== sv/bounded_max_priority_queue.sv =====
// Top level of the bounded max priority queue: sequencer, entry RAM, output register.
// Depends on bmpq_pkg, bmpq_ram and bmpq_seq.
//
// Sorted-array max priority queue of CAPACITY signed 32-bit entries, held in
// ascending order in a RAM with one write and one read port, so the largest
// sits in the top slot. One operation is taken at a time; o_in_ready is high
// only while the sequencer is idle. A refused insert, a failed remove/peek or
// an unused mode goes from idle straight to S_DONE; a remove or peek passes
// through S_POP; an insert steps through S_INS_CMP as it moves each larger
// entry up a slot, and through S_INS_PUT at the bottom slot or on an empty
// queue, since the one comparator and the one RAM write port handle one entry
// per cycle. The block takes its next word in the cycle after the result is
// loaded. A finished result sits in the output register, so a new word can be
// accepted while the previous result waits for i_out_ready; the next result
// then holds the sequencer, and with it the input, until that register frees up.
module bounded_max_priority_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bmpq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmpq_pkg::t_out_word o_out_word
);
    import bmpq_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_wdata;
    logic [DATA_W-1:0] w_rdata;
    logic              w_done;
    logic              w_take;
    t_out_word         w_res_word;

    logic      r_out_valid;
    t_out_word r_out_word;

    // Output slot free, or being emptied this cycle
    assign w_take = w_done && (!r_out_valid || i_out_ready);

    bmpq_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_done     (w_done),
        .i_take     (w_take),
        .o_out_word (w_res_word),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    bmpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register word
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_word <= w_res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sv/bmpq_checker.sv =====
// Port-level checker for the bounded max priority queue, bound to the top level.
// Depends on bmpq_pkg.
module bmpq_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bmpq_pkg::t_out_word o_out_word
);
    import bmpq_pkg::*;

    // One operation at a time: the input closes right after a word is taken
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted word");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // Overflow only when the queue is full
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_OVERFLOW) |->
            (o_out_word.count == COUNT_W'(CAPACITY) && !o_out_word.is_empty
             && o_out_word.result_value == '0))
        else $error("overflow reported on a queue that is not full");

    // Underflow only on an empty queue, with a zero value
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_UNDERFLOW) |->
            (o_out_word.is_empty && o_out_word.result_value == '0))
        else $error("underflow reported on a non-empty queue");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((CAPACITY > 31) || (o_out_word.is_empty == (o_out_word.count == '0))))
        else $error("empty flag disagrees with count");

endmodule

bind bounded_max_priority_queue bmpq_checker #(
    .CAPACITY (CAPACITY)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== verif/bmpq_test_pkg.sv =====
// Scoreboard for the bounded max priority queue testbench.
// Depends on bmpq_pkg for the word types and the operation and status codes.
package bmpq_test_pkg;

    import bmpq_pkg::*;

    // The mode field has one code the block treats as a no-op
    localparam logic [1:0] MODE_NOP = 2'd3;

    // Max-priority-queue predictor plus the queue of results still to come
    class bmpq_scoreboard #(int unsigned DEPTH = 16);

        logic signed [DATA_W-1:0] sorted_slots [DEPTH];
        int unsigned              held;
        t_out_word                expected_words [$];
        int unsigned              fail_count;
        int unsigned              word_index;

        function new();
            held       = 0;
            fail_count = 0;
            word_index = 0;
        endfunction

        // Apply one accepted operation to the model and queue its result word
        function void apply_operation(t_in_word w);
            t_out_word   want;
            int unsigned pos;
            want = '0;
            want.status = ST_OK;
            case (w.mode) inside
                MODE_INSERT: begin
                    if (held >= DEPTH) begin
                        want.status = ST_OVERFLOW;
                    end else begin
                        // ordered insertion: larger entries move up one slot
                        pos = held;
                        while (pos > 0 && sorted_slots[pos-1] > w.value) begin
                            sorted_slots[pos] = sorted_slots[pos-1];
                            pos--;
                        end
                        sorted_slots[pos] = w.value;
                        held++;
                    end
                end
                MODE_REMOVE, MODE_PEEK: begin
                    if (held == 0) begin
                        want.status = ST_UNDERFLOW;
                    end else begin
                        want.result_value = sorted_slots[held-1];
                        if (w.mode == MODE_REMOVE) begin
                            held--;
                        end
                    end
                end
                default: begin
                    // no-op, queue untouched
                end
            endcase
            want.is_empty = (held == 0);
            want.count    = held[COUNT_W-1:0];
            expected_words.push_back(want);
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        // One line per mismatch, and count it
        task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            fail_count++;
            $display("mismatch at result word %0d, %s: got %h, want %h",
                     word_index, what, got, want);
        endtask

        // Compare one accepted result word with the oldest expectation
        task check_result(t_out_word got);
            t_out_word want;
            word_index++;
            if (expected_words.size() == 0) begin
                report("word with nothing expected", got.result_value, '0);
                return;
            end
            want = expected_words.pop_front();
            if (got.result_value !== want.result_value)
                report("result_value", got.result_value, want.result_value);
            if (got.status !== want.status)
                report("status", DATA_W'(got.status), DATA_W'(want.status));
            if (got.is_empty !== want.is_empty)
                report("is_empty", DATA_W'(got.is_empty), DATA_W'(want.is_empty));
            if (got.count !== want.count)
                report("count", DATA_W'(got.count), DATA_W'(want.count));
        endtask

        // Anything still queued at the end never came out of the block
        task flush_leftover();
            t_out_word want;
            while (expected_words.size() != 0) begin
                want = expected_words.pop_front();
                report("result never arrived", '0, want.result_value);
            end
        endtask

    endclass

endpackage

// ===== verif/bounded_max_priority_queue_test.sv =====
// Testbench top for the bounded max priority queue: clock, reset, drivers, monitor.
// Depends on bmpq_pkg, bmpq_test_pkg and the bounded_max_priority_queue RTL.
module bounded_max_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bmpq_pkg::*;
    import bmpq_test_pkg::*;

    localparam int unsigned CAPACITY     = 16;
    localparam int unsigned RANDOM_WORDS = 1750;
    localparam int unsigned CALM_TAIL    = 200;   // last words sent with no idling
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned HOLD_AT      = 600;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 40;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    bmpq_test_pkg::bmpq_scoreboard #(.DEPTH(CAPACITY)) sb = new();

    bit          idle_on = 1'b1;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned rx_stall_left = 0;
    int unsigned stall_cycles = 0;

    bounded_max_priority_queue #(.CAPACITY(CAPACITY)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_in_word make_word(logic [1:0] m, logic signed [DATA_W-1:0] v);
        t_in_word w;
        w.mode  = m;
        w.value = v;
        return w;
    endfunction

    // Values lean on extremes and a narrow band so equal entries are common
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9)) inside
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // insert_pct steers the fill level; 3 percent are no-ops, rest split between remove and peek
    function automatic logic [1:0] pick_mode(int unsigned insert_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_NOP;
        if (r < 3 + insert_pct)
            return MODE_INSERT;
        return ($urandom_range(0, 9) < 7) ? MODE_REMOVE : MODE_PEEK;
    endfunction

    // Offer one word from a falling edge, hold it until taken, end on a falling edge
    task automatic drive_word(t_in_word w);
        if (idle_on && $urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.apply_operation(w);
        @(negedge i_clk);
    endtask

    // Receiver: short random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            out_ready <= 1'b0;
            rx_stall_left = LONG_HOLD - 1;
        end else if (idle_on && $urandom_range(0, 99) < rx_idle_pct) begin
            out_ready <= 1'b0;
            rx_stall_left = $urandom_range(0, 3);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            sb.check_result(out_word);
        end
    end

    // Watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned sent;
        int unsigned block_left;
        int unsigned insert_pct;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue: underflow on remove and peek, no-op
        drive_word(make_word(MODE_PEEK, VAL_MAX));
        drive_word(make_word(MODE_REMOVE, VAL_MIN));
        drive_word(make_word(MODE_NOP, -1));
        // extremes and signed ordering around zero, duplicate largest
        drive_word(make_word(MODE_INSERT, VAL_MAX));
        drive_word(make_word(MODE_INSERT, VAL_MIN));
        drive_word(make_word(MODE_INSERT, 0));
        drive_word(make_word(MODE_INSERT, -1));
        drive_word(make_word(MODE_INSERT, 1));
        drive_word(make_word(MODE_INSERT, VAL_MAX));
        drive_word(make_word(MODE_PEEK, 0));
        drive_word(make_word(MODE_REMOVE, 0));
        drive_word(make_word(MODE_REMOVE, 0));
        drive_word(make_word(MODE_NOP, 32'shAAAA_AAAA));
        // fill to capacity; negative values force long shifts
        for (int i = 0; i < 12; i++) begin
            drive_word(make_word(MODE_INSERT,
                (i % 2) ? 32'sh5555_5555 - i : 32'shAAAA_AAAA + i));
        end
        drive_word(make_word(MODE_INSERT, 7));
        drive_word(make_word(MODE_REMOVE, 0));

        // Random part in blocks that push toward full, toward empty, or mix
        sent = 0;
        block_left = 0;
        insert_pct = 50;
        while (sent < RANDOM_WORDS) begin
            if (block_left == 0) begin
                block_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 20;
                    default: insert_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0:       tx_idle_pct = 0;
                    1:       tx_idle_pct = 15;
                    default: tx_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       rx_idle_pct = 0;
                    1:       rx_idle_pct = 5;
                    default: rx_idle_pct = 15;
                endcase
            end
            if (sent == HOLD_AT)
                hold_request = 1'b1;
            if (sent == RANDOM_WORDS - CALM_TAIL)
                idle_on = 1'b0;
            drive_word(make_word(pick_mode(insert_pct), pick_value()));
            block_left--;
            sent++;
        end
        in_valid <= 1'b0;

        // Let the last results drain, then watch for strays
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flush_leftover();
        if (sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
